FILE: design/cst_pkg.sv
// Package for the counting semaphore table: word types and sizing constants.
// Used by counting_semaphore_table_top; depends on nothing.
`timescale 1ns / 1ps
package cst_pkg;
    localparam int SLOT_COUNT  = 16;
    localparam int NAME_BYTES  = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int PID_BITS    = 8;
    localparam int SLOT_BITS   = 4;
    localparam int QPTR_BITS   = 3;
    localparam int FILL_BITS   = 4;

    localparam logic [1:0] FUNC_OPEN  = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_WAIT  = 2'd2;
    localparam logic [1:0] FUNC_POST  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [55:0] name_key;
        logic [15:0] initial_value;
        logic [7:0]  sem_index;
        logic [7:0]  caller_pid;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic       caller_blocked;
        logic       wake_valid;
        logic [7:0] wake_pid;
    } t_out_word;

    function automatic logic [55:0] norm_name(input logic [55:0] key);
        logic [55:0] r;
        logic        live;
        r = '0;
        live = 1'b1;
        for (int i = 0; i < NAME_BYTES - 1 && i < 7; i++) begin
            if (key[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*i +: 8] = key[8*i +: 8];
        end
        return r;
    endfunction
endpackage

FILE: design/counting_semaphore_table_top.sv
// Counting semaphore table: named slots with counts and FIFO wait queues.
// Depends on cst_pkg.
`timescale 1ns / 1ps
// Each word is accepted in S_IDLE, which registers the slot address for the slot and queue
// memories; S_READ does the registered queue read; S_EXEC writes back and registers the
// result. Open and close search the 16 names held in flip-flops combinationally. The wait
// queues sit in a 128-entry memory that needs no clearing; slot and queue state resets.
module counting_semaphore_table_top import cst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]  r_state, n_state;
    t_in_word    r_in;
    logic [55:0] r_names [SLOT_COUNT];
    logic [15:0] r_counts [SLOT_COUNT];
    logic [QPTR_BITS-1:0] r_heads [SLOT_COUNT];
    logic [FILL_BITS-1:0] r_fill [SLOT_COUNT];
    logic [PID_BITS-1:0]  r_wait_mem [SLOT_COUNT*QUEUE_DEPTH];
    logic [PID_BITS-1:0]  r_rd_pid;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [55:0] w_name;
    logic [SLOT_BITS-1:0] w_idx;
    logic        w_bad;
    logic [15:0] w_cnt;
    logic [QPTR_BITS-1:0] w_head, w_tail;
    logic [FILL_BITS-1:0] w_fill;
    logic        w_hit, w_free;
    logic [SLOT_BITS-1:0] w_hit_s, w_free_s;
    t_out_word   w_res;
    logic        w_qwr;

    assign w_name = norm_name(r_in.name_key);
    assign w_idx  = r_in.sem_index[SLOT_BITS-1:0];
    assign w_bad  = r_in.sem_index[7:SLOT_BITS] != '0;
    assign w_cnt  = r_counts[w_idx];
    assign w_head = r_heads[w_idx];
    assign w_fill = r_fill[w_idx];
    assign w_tail = w_head + w_fill[QPTR_BITS-1:0];

    always_comb begin
        w_hit = 1'b0; w_hit_s = '0; w_free = 1'b0; w_free_s = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (w_name != '0 && r_names[i] == w_name) begin
                w_hit = 1'b1; w_hit_s = SLOT_BITS'(i);
            end
            if (r_names[i] == '0) begin
                w_free = 1'b1; w_free_s = SLOT_BITS'(i);
            end
        end
    end

    always_comb begin
        w_res = '0;
        w_qwr = 1'b0;
        case (r_in.func)
            FUNC_OPEN: begin
                if (w_hit) w_res.slot = w_hit_s;
                else if (w_free) w_res.slot = w_free_s;
                else w_res.status = ST_MISS;
            end
            FUNC_CLOSE: begin
                if (w_hit) w_res.slot = w_hit_s;
                else w_res.status = ST_MISS;
            end
            FUNC_WAIT: begin
                if (w_bad) w_res.status = ST_MISS;
                else if (w_cnt == '0) begin
                    if (w_fill >= FILL_BITS'(QUEUE_DEPTH)) w_res.status = ST_FULL;
                    else begin
                        w_res.caller_blocked = 1'b1;
                        w_qwr = 1'b1;
                    end
                end
            end
            default: begin
                if (w_bad) w_res.status = ST_MISS;
                else if (w_fill != '0) begin
                    w_res.wake_valid = 1'b1;
                    w_res.wake_pid   = r_rd_pid;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid && o_ready) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ)
            r_rd_pid <= r_wait_mem[{w_idx, w_head}];
        if (r_state == S_EXEC && w_qwr)
            r_wait_mem[{w_idx, w_tail}] <= r_in.caller_pid;
        if (i_valid && o_ready) r_in <= i_data;
        if (r_state == S_EXEC) r_out <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_names[i] <= '0; r_counts[i] <= '0;
                r_heads[i] <= '0; r_fill[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (r_state == S_EXEC) begin
                case (r_in.func)
                    FUNC_OPEN: begin
                        if (!w_hit && w_free) begin
                            r_names[w_free_s]  <= w_name;
                            r_counts[w_free_s] <= r_in.initial_value;
                        end
                    end
                    FUNC_CLOSE: if (w_hit) r_names[w_hit_s] <= '0;
                    FUNC_WAIT: begin
                        if (!w_bad) begin
                            if (w_cnt != '0) r_counts[w_idx] <= w_cnt - 16'd1;
                            else if (w_qwr) r_fill[w_idx] <= w_fill + FILL_BITS'(1);
                        end
                    end
                    default: begin
                        if (!w_bad) begin
                            if (w_fill != '0) begin
                                r_heads[w_idx] <= w_head + QPTR_BITS'(1);
                                r_fill[w_idx]  <= w_fill - FILL_BITS'(1);
                            end else if (w_cnt != 16'hFFFF) begin
                                r_counts[w_idx] <= w_cnt + 16'd1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_valid) else $error("result not raised");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.wake_valid || o_data.caller_blocked) |-> o_data.status == ST_OK)
        else $error("flag with error status");
endmodule
